// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks, clocked on clk and disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Transaction types, action codes and status codes shared by the deque blocks.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACTION_BITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 9;

    // Action codes carried in the input transaction.
    localparam logic [ACTION_BITS-1:0] ACT_PUSH_FRONT   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PUSH_BACK    = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_POP_FRONT    = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_CURSOR_FIRST = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_CURSOR_NEXT  = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_CURSOR_WRITE = 3'd5;

    // Status reported with every result.
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_PAST_END = 2'd3
    } status_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0]       action;
        logic signed [VALUE_BITS-1:0] value;
    } bdq_in_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] front_value;
        logic [COUNT_BITS-1:0]        entry_count;
        logic signed [VALUE_BITS-1:0] cursor_value;
        logic                         cursor_past_end;
        status_t                      status;
    } bdq_out_t;

    // Queue state after a step, apart from the stored elements.
    typedef struct packed {
        logic [COUNT_BITS-1:0] entry_count;
        logic                  empty;
        logic                  past_end;
        status_t               status;
    } bdq_meta_t;

endpackage

// ===== hdl/bounded_deque_with_cursor_top.sv =====
// Bounded deque with cursor: ring store of DEPTH elements, one action per transaction.
// A result passes the input register, then the result register, before it is offered.
// One transaction per cycle unless stalled; a step: at most one write, two store reads.
// Reset clears front, count and cursor and puts the cursor past the end.
// The element store is not cleared; reads of unwritten slots are masked to zero.
// ----------------------------------------------------------------------------
// Bounded deque with cursor, top level
// Input register, pointer control, element store and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_cursor_top
    import bdq_pkg::*;
#(
    parameter int DEPTH        = 256,
    parameter int ELEMENT_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bdq_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output bdq_out_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    in_valid_reg;
    bdq_in_t                 in_data_reg;
    logic                    out_valid_reg;
    bdq_meta_t               meta_reg;
    logic                    front_hit_reg;
    logic                    cursor_hit_reg;
    logic [ELEMENT_BITS-1:0] bypass_reg;

    logic                    advance;
    logic                    step;
    logic [63:0]             in_ext;
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [ELEMENT_BITS-1:0] ram_wr_data;
    logic [AW-1:0]           rd_front_addr;
    logic [AW-1:0]           rd_cursor_addr;
    logic [ELEMENT_BITS-1:0] rd_front_data;
    logic [ELEMENT_BITS-1:0] rd_cursor_data;
    bdq_meta_t               meta;
    logic [ELEMENT_BITS-1:0] front_word;
    logic [ELEMENT_BITS-1:0] cursor_word;
    logic [63:0]             front_ext;
    logic [63:0]             cursor_ext;

    // Pipeline moves when the result register is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // Element width conversion of the incoming value.
    assign in_ext = 64'($signed(in_data_reg.value));

    bdq_ctrl #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .action         (in_data_reg.action),
        .elem           (in_ext[ELEMENT_BITS-1:0]),
        .wr_en          (ram_wr_en),
        .wr_addr        (ram_wr_addr),
        .wr_data        (ram_wr_data),
        .rd_front_addr  (rd_front_addr),
        .rd_cursor_addr (rd_cursor_addr),
        .meta           (meta)
    );

    bdq_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_en     (advance),
        .rd_addr_a (rd_front_addr),
        .rd_addr_b (rd_cursor_addr),
        .rd_data_a (rd_front_data),
        .rd_data_b (rd_cursor_data)
    );

    // Result register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register: summary and forwarding of a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta_reg       <= meta;
            front_hit_reg  <= ram_wr_en && (ram_wr_addr == rd_front_addr);
            cursor_hit_reg <= ram_wr_en && (ram_wr_addr == rd_cursor_addr);
            bypass_reg     <= ram_wr_data;
        end
    end

    // Output transaction.
    always_comb
    begin
        front_word  = front_hit_reg ? bypass_reg : rd_front_data;
        cursor_word = cursor_hit_reg ? bypass_reg : rd_cursor_data;
        front_ext   = 64'($signed(front_word));
        cursor_ext  = 64'($signed(cursor_word));

        out_data.front_value     = meta_reg.empty ? '0 : front_ext[VALUE_BITS-1:0];
        out_data.entry_count     = meta_reg.entry_count;
        out_data.cursor_value    = meta_reg.past_end ? '0 : cursor_ext[VALUE_BITS-1:0];
        out_data.cursor_past_end = meta_reg.past_end;
        out_data.status          = meta_reg.status;
    end

    assign out_valid = out_valid_reg;

    // Checks.
    `ASSERT_ALWAYS(a_write_only_on_step, ram_wr_en |-> step, "store written without a step")
    `ASSERT_ALWAYS(a_cursor_needs_entry, (out_valid_reg && !meta_reg.past_end) |-> !meta_reg.empty, "cursor on an empty queue")
    `ASSERT_ALWAYS(a_empty_refusal, (out_valid_reg && meta_reg.status == ST_EMPTY) |-> meta_reg.empty, "empty refusal with entries")
    `ASSERT_NEVER(a_stall_cause, in_stall && !(out_valid_reg && out_stall), "input stalled without output backpressure")

endmodule

// ===== hdl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hdl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque pointer control
// Holds front slot, count and cursor, decodes one action per step and
// drives the element store's write and read addresses.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH        = 256,
    parameter int ELEMENT_BITS = 32,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [ACTION_BITS-1:0]  action,
    input  logic [ELEMENT_BITS-1:0] elem,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [ELEMENT_BITS-1:0] wr_data,
    output logic [AW-1:0]           rd_front_addr,
    output logic [AW-1:0]           rd_cursor_addr,
    output bdq_meta_t               meta
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic          past_end_reg, past_end_next;

    logic          full;
    logic          empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] cursor_inc;
    logic [CW:0]   tail_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] last_slot;
    status_t       status;

    // Neighbor slots on the ring.
    always_comb
    begin
        full       = (count_reg == CW'(DEPTH));
        empty      = (count_reg == '0);
        front_dec  = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
        front_inc  = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
        cursor_inc = (cursor_reg == LAST_SLOT) ? '0 : cursor_reg + 1'b1;
        tail_sum   = (CW + 1)'(front_reg) + (CW + 1)'(count_reg);
        if (tail_sum >= DEPTH_W)
        begin
            tail_sum = tail_sum - DEPTH_W;
        end
        tail_slot  = tail_sum[AW-1:0];
        last_slot  = (tail_slot == '0) ? LAST_SLOT : tail_slot - 1'b1;
    end

    // Action decode.
    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        past_end_next = past_end_reg;
        wr_en         = 1'b0;
        wr_addr       = cursor_reg;
        status        = ST_DONE;
        case (action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                    wr_en      = step;
                    wr_addr    = front_dec;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    wr_en      = step;
                    wr_addr    = tail_slot;
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                    // Popping the entry under the cursor moves it to the new front, or past the end if none is left.
                    if (!past_end_reg && cursor_reg == front_reg)
                    begin
                        cursor_next   = front_inc;
                        past_end_next = (count_reg == CW'(1));
                    end
                end
            end
            ACT_CURSOR_FIRST:
            begin
                cursor_next   = front_reg;
                past_end_next = empty;
            end
            ACT_CURSOR_NEXT:
            begin
                if (past_end_reg)
                begin
                    status = ST_PAST_END;
                end
                else if (empty || cursor_reg == last_slot)
                begin
                    past_end_next = 1'b1;
                end
                else
                begin
                    cursor_next = cursor_inc;
                end
            end
            ACT_CURSOR_WRITE:
            begin
                if (past_end_reg)
                begin
                    status = ST_PAST_END;
                end
                else
                begin
                    wr_en   = step;
                    wr_addr = cursor_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign wr_data        = elem;
    assign rd_front_addr  = front_next;
    assign rd_cursor_addr = cursor_next;

    // Result summary for the output stage.
    always_comb
    begin
        meta.entry_count = COUNT_BITS'(count_next);
        meta.empty       = (count_next == '0);
        meta.past_end    = past_end_next;
        meta.status      = status;
    end

    // Pointer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            past_end_reg <= 1'b1;
        end
        else if (step)
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            past_end_reg <= past_end_next;
        end
    end

endmodule
